@@ hw/rtl/mpfb_pkg.sv @@
`default_nettype none

package mpfb_pkg;

    // Panel geometry
    localparam int COLUMNS    = 128;
    localparam int PAGES      = 8;
    localparam int HEADER_LEN = 3;
    localparam int STORE_SIZE = PAGES * COLUMNS;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int POS_W      = $clog2(COLUMNS + HEADER_LEN);

    // Bus control prefixes and page-mode command bytes
    localparam logic [6:0] CTRL_COMMAND = 7'h00;
    localparam logic [6:0] CTRL_DATA    = 7'h40;
    localparam logic [7:0] PAGE_BASE    = 8'hB0;
    localparam logic [7:0] COL_LOW_CMD  = 8'h00;
    localparam logic [7:0] COL_HIGH_CMD = 8'h10;

    typedef enum logic [2:0] {
        CMD_SET_PIXEL = 3'd0,
        CMD_CLR_PIXEL = 3'd1,
        CMD_CLEAR_ALL = 3'd2,
        CMD_REFRESH   = 3'd3,
        CMD_RAW       = 3'd4
    } t_cmd;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // What the scanner says about the next refresh byte
    typedef struct packed {
        logic              is_data;
        logic [7:0]        header_byte;
        logic              frame_end;
        logic [ADDR_W-1:0] addr;
    } t_scan_info;

endpackage

`default_nettype wire

@@ hw/rtl/mpfb_if.sv @@
`default_nettype none

interface mpfb_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    logic [7:0] raw_value;
    logic       raw_is_data;

    modport source (output valid, command, pixel_x, pixel_y, raw_value, raw_is_data,
                    input ready);
    modport sink   (input valid, command, pixel_x, pixel_y, raw_value, raw_is_data,
                    output ready);
endinterface

interface mpfb_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] control_byte;
    logic [7:0] payload;
    logic       frame_end;

    modport source (output valid, control_byte, payload, frame_end, input ready);
    modport sink   (input valid, control_byte, payload, frame_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mpfb_scan.sv @@
`default_nettype none

module mpfb_scan (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_advance,
    input  wire                  i_rewind,
    output mpfb_pkg::t_scan_info o_info
);

    localparam int LAST_POS = mpfb_pkg::COLUMNS + mpfb_pkg::HEADER_LEN - 1;

    logic [mpfb_pkg::PAGE_W-1:0] r_page, n_page;
    logic [mpfb_pkg::POS_W-1:0]  r_pos,  n_pos;
    logic                        pos_last;

    assign pos_last = (int'(r_pos) == LAST_POS);

    always_comb begin
        n_page = r_page;
        n_pos  = r_pos;
        priority if (i_rewind) begin
            n_page = '0;
            n_pos  = '0;
        end else if (i_advance) begin
            if (pos_last) begin
                n_pos = '0;
                if (int'(r_page) == mpfb_pkg::PAGES - 1) begin
                    n_page = '0;
                end else begin
                    n_page = r_page + 1'b1;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= '0;
            r_pos  <= '0;
        end else begin
            r_page <= n_page;
            r_pos  <= n_pos;
        end
    end

    // Header bytes at positions 0..2, store bytes after
    always_comb begin
        o_info.is_data   = (int'(r_pos) >= mpfb_pkg::HEADER_LEN);
        o_info.frame_end = o_info.is_data && pos_last &&
                           (int'(r_page) == mpfb_pkg::PAGES - 1);
        o_info.addr      = mpfb_pkg::ADDR_W'(int'(r_page) * mpfb_pkg::COLUMNS +
                                             int'(r_pos) - mpfb_pkg::HEADER_LEN);
        if (int'(r_pos) == 0) begin
            o_info.header_byte = mpfb_pkg::PAGE_BASE + 8'(r_page);
        end else if (int'(r_pos) == 1) begin
            o_info.header_byte = mpfb_pkg::COL_LOW_CMD;
        end else begin
            o_info.header_byte = mpfb_pkg::COL_HIGH_CMD;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mono_page_framebuffer_scanout.sv @@
`default_nettype none
// Page-organized monochrome frame buffer with refresh scanner.
//
// i_req carries one request per valid/ready handshake: set pixel, clear
// pixel, clear all, next refresh byte, or raw controller byte. o_rsp carries
// one response (control byte 0x00/0x40, payload, frame_end) for each refresh
// or raw request; pixel and clear requests produce none.
//
// Timing: a request enters at most once per clock. Stage one issues the
// store read, stage two merges the pixel or picks the byte, and the response
// is then held in the output register until it is taken. Sustained rate,
// set by the 1024 x 8 store with one read and one write port, is one request
// per cycle while no sweep runs and o_rsp is not held off: each pixel update
// is a read-modify-write, and a back-to-back hit is forwarded.
//
// Reset and clear all: the store is swept to zero, one byte per cycle, and
// i_req.ready stays low through the sweep. Clear all also rewinds the
// scanner to page 0. Responses already queued still drain.
//
// Stall: while o_rsp is held off, a pending refresh or raw byte waits in
// stage two and i_req.ready drops; pixel writes behind it wait as well.
module mono_page_framebuffer_scanout (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mpfb_req_if.sink    i_req,
    mpfb_rsp_if.source  o_rsp
);

    localparam int AW = mpfb_pkg::ADDR_W;

    // Pixel store: one write, one registered read per cycle
    logic [7:0] mem [mpfb_pkg::STORE_SIZE];

    mpfb_pkg::t_state   r_state, n_state;
    logic [AW-1:0]      r_sweep, n_sweep;
    mpfb_pkg::t_cmd     cmd;
    mpfb_pkg::t_scan_info scan_info;

    logic               req_fire;
    logic [2:0]         pix_page;
    logic               pix_ok;
    logic [AW-1:0]      pix_addr;
    logic [7:0]         pix_mask;
    logic [AW-1:0]      rd_addr;

    // Stage two
    logic               r_s2_vld, n_s2_vld;
    logic               r_s2_wr, n_s2_wr;
    logic               r_s2_set;
    logic [7:0]         r_s2_mask;
    logic [AW-1:0]      r_s2_addr, n_s2_addr;
    logic               r_s2_res, n_s2_res;
    logic               r_s2_from_mem, n_s2_from_mem;
    logic [6:0]         r_s2_ctrl, n_s2_ctrl;
    logic [7:0]         r_s2_byte, n_s2_byte;
    logic               r_s2_end, n_s2_end;
    logic [7:0]         r_rdata;

    // Last write, for read-after-write forwarding
    logic               r_fw_vld;
    logic [AW-1:0]      r_fw_addr;
    logic [7:0]         r_fw_data;

    logic [7:0]         cur_byte;
    logic [7:0]         new_byte;
    logic               out_free;
    logic               s2_go;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;

    logic               r_out_vld;
    logic [6:0]         r_out_ctrl;
    logic [7:0]         r_out_byte;
    logic               r_out_end;

    assign cmd      = mpfb_pkg::t_cmd'(i_req.command);
    assign req_fire = i_req.valid && i_req.ready;

    // Locate the pixel: page from the row, bit from the row's low three bits
    assign pix_page = i_req.pixel_y[5:3];
    assign pix_ok   = (int'(i_req.pixel_x) < mpfb_pkg::COLUMNS) &&
                      (int'(pix_page) < mpfb_pkg::PAGES);
    assign pix_addr = AW'(int'(pix_page) * mpfb_pkg::COLUMNS + int'(i_req.pixel_x));
    assign pix_mask = 8'd1 << i_req.pixel_y[2:0];
    assign rd_addr  = (cmd == mpfb_pkg::CMD_REFRESH) ? scan_info.addr : pix_addr;

    mpfb_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (req_fire && (cmd == mpfb_pkg::CMD_REFRESH)),
        .i_rewind  (req_fire && (cmd == mpfb_pkg::CMD_CLEAR_ALL)),
        .o_info    (scan_info)
    );

    // Stage two: merge with forwarding, advance unless a response is blocked
    assign cur_byte = (r_fw_vld && (r_fw_addr == r_s2_addr)) ? r_fw_data : r_rdata;
    assign new_byte = r_s2_set ? (cur_byte | r_s2_mask) : (cur_byte & ~r_s2_mask);
    assign out_free = !r_out_vld || o_rsp.ready;
    assign s2_go    = !r_s2_vld || !r_s2_res || out_free;

    assign i_req.ready = (r_state == mpfb_pkg::ST_RUN) && s2_go;

    // Sweep owns the write port while clearing; stage two is empty then
    assign wr_en   = (r_state == mpfb_pkg::ST_CLEAR) || (r_s2_vld && r_s2_wr);
    assign wr_addr = (r_state == mpfb_pkg::ST_CLEAR) ? r_sweep : r_s2_addr;
    assign wr_data = (r_state == mpfb_pkg::ST_CLEAR) ? 8'h00 : new_byte;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (req_fire) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Clear sweep control
    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        unique case (r_state)
            mpfb_pkg::ST_CLEAR: begin
                n_sweep = r_sweep + 1'b1;
                if (int'(r_sweep) == mpfb_pkg::STORE_SIZE - 1) begin
                    n_state = mpfb_pkg::ST_RUN;
                end
            end
            mpfb_pkg::ST_RUN: begin
                if (req_fire && (cmd == mpfb_pkg::CMD_CLEAR_ALL)) begin
                    n_state = mpfb_pkg::ST_CLEAR;
                    n_sweep = '0;
                end
            end
            default: begin
                n_state = mpfb_pkg::ST_CLEAR;
                n_sweep = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpfb_pkg::ST_CLEAR;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
        end
    end

    // Stage-two occupancy: clear all and unused codes leave it empty
    always_comb begin
        n_s2_vld = 1'b0;
        if (req_fire) begin
            unique case (cmd)
                mpfb_pkg::CMD_SET_PIXEL,
                mpfb_pkg::CMD_CLR_PIXEL,
                mpfb_pkg::CMD_REFRESH,
                mpfb_pkg::CMD_RAW:       n_s2_vld = 1'b1;
                default:                 n_s2_vld = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_go) begin
            r_s2_vld <= n_s2_vld;
        end
    end

    // Decode the request into stage-two contents
    always_comb begin
        n_s2_wr       = 1'b0;
        n_s2_addr     = pix_addr;
        n_s2_res      = 1'b0;
        n_s2_from_mem = 1'b0;
        n_s2_ctrl     = mpfb_pkg::CTRL_COMMAND;
        n_s2_byte     = i_req.raw_value;
        n_s2_end      = 1'b0;
        unique case (cmd)
            mpfb_pkg::CMD_SET_PIXEL,
            mpfb_pkg::CMD_CLR_PIXEL: begin
                n_s2_wr = pix_ok;
            end
            mpfb_pkg::CMD_REFRESH: begin
                n_s2_res      = 1'b1;
                n_s2_addr     = scan_info.addr;
                n_s2_from_mem = scan_info.is_data;
                n_s2_ctrl     = scan_info.is_data ? mpfb_pkg::CTRL_DATA
                                                  : mpfb_pkg::CTRL_COMMAND;
                n_s2_byte     = scan_info.header_byte;
                n_s2_end      = scan_info.frame_end;
            end
            mpfb_pkg::CMD_RAW: begin
                n_s2_res  = 1'b1;
                n_s2_ctrl = i_req.raw_is_data ? mpfb_pkg::CTRL_DATA
                                              : mpfb_pkg::CTRL_COMMAND;
            end
            default: begin
                n_s2_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s2_wr       <= n_s2_wr;
            r_s2_set      <= (cmd == mpfb_pkg::CMD_SET_PIXEL);
            r_s2_mask     <= pix_mask;
            r_s2_addr     <= n_s2_addr;
            r_s2_res      <= n_s2_res;
            r_s2_from_mem <= n_s2_from_mem;
            r_s2_ctrl     <= n_s2_ctrl;
            r_s2_byte     <= n_s2_byte;
            r_s2_end      <= n_s2_end;
        end
    end

    // Forwarding register: hold while stage two is blocked, drop on a sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else if (r_state == mpfb_pkg::ST_CLEAR) begin
            r_fw_vld <= 1'b0;
        end else if (s2_go) begin
            r_fw_vld <= r_s2_vld && r_s2_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_fw_addr <= r_s2_addr;
            r_fw_data <= new_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_go && r_s2_vld && r_s2_res) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && r_s2_vld && r_s2_res) begin
            r_out_ctrl <= r_s2_ctrl;
            r_out_byte <= r_s2_from_mem ? cur_byte : r_s2_byte;
            r_out_end  <= r_s2_end;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.control_byte = r_out_ctrl;
    assign o_rsp.payload      = r_out_byte;
    assign o_rsp.frame_end    = r_out_end;

endmodule

`default_nettype wire

@@ hw/rtl/mpfb_checker.sv @@
`default_nettype none

module mpfb_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_req_ready,
    input wire       i_rsp_valid,
    input wire       i_rsp_ready,
    input wire [6:0] i_rsp_control_byte,
    input wire [7:0] i_rsp_payload,
    input wire       i_rsp_frame_end
);

    // A stalled response holds its contents
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_payload) &&
            $stable(i_rsp_control_byte) && $stable(i_rsp_frame_end))
        else $error("response changed while stalled");

    // Only the two bus prefixes ever appear
    a_ctrl_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_control_byte == mpfb_pkg::CTRL_COMMAND) ||
            (i_rsp_control_byte == mpfb_pkg::CTRL_DATA))
        else $error("bad control byte");

    // Frame end marks a data byte
    a_end_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_frame_end |-> i_rsp_control_byte == mpfb_pkg::CTRL_DATA)
        else $error("frame end on a command byte");

    // Reset starts the clearing sweep, so requests are held off
    a_rst_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request taken right after reset");

endmodule

bind mono_page_framebuffer_scanout mpfb_checker u_mpfb_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_control_byte (o_rsp.control_byte),
    .i_rsp_payload      (o_rsp.payload),
    .i_rsp_frame_end    (o_rsp.frame_end)
);

`default_nettype wire

@@ tb/tb_mono_page_framebuffer_scanout.sv @@
`default_nettype none

module tb_mono_page_framebuffer_scanout;

    // Codes 5..7 are unused by the block: they must be swallowed silently
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

    localparam int RANDOM_PER_PHASE = 140;
    // A clear sweep holds ready low for a whole store pass; allow several times that
    localparam int WATCHDOG_LIMIT   = 4 * mpfb_pkg::STORE_SIZE;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
        logic [7:0] raw_value;
        logic       raw_is_data;
    } t_panel_req;

    typedef struct packed {
        logic [6:0] control_byte;
        logic [7:0] payload;
        logic       frame_end;
    } t_panel_byte;

    // Shadow frame buffer and scanner; predicts every byte sent to the panel
    class panel_scoreboard;
        logic [7:0]  shadow_store [mpfb_pkg::STORE_SIZE];
        int unsigned scan_page;
        int unsigned scan_pos;
        t_panel_byte bytes_due [$];
        int unsigned mismatches;
        int unsigned bytes_checked;
        int unsigned frames_seen;
        int unsigned clears_seen;

        function new();
            foreach (shadow_store[i]) shadow_store[i] = 8'h00;
            scan_page     = 0;
            scan_pos      = 0;
            mismatches    = 0;
            bytes_checked = 0;
            frames_seen   = 0;
            clears_seen   = 0;
        endfunction

        function void note_request(t_panel_req r);
            int unsigned col;
            int unsigned page;
            int unsigned addr;
            t_panel_byte b;
            col  = r.pixel_x;
            page = r.pixel_y >> 3;
            addr = page * mpfb_pkg::COLUMNS + col;
            b    = '0;
            case (r.command)
                mpfb_pkg::CMD_SET_PIXEL: begin
                    if (col < mpfb_pkg::COLUMNS && page < mpfb_pkg::PAGES)
                        shadow_store[addr] = shadow_store[addr] | (8'h01 << r.pixel_y[2:0]);
                end
                mpfb_pkg::CMD_CLR_PIXEL: begin
                    if (col < mpfb_pkg::COLUMNS && page < mpfb_pkg::PAGES)
                        shadow_store[addr] = shadow_store[addr] & ~(8'h01 << r.pixel_y[2:0]);
                end
                mpfb_pkg::CMD_CLEAR_ALL: begin
                    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
                    scan_page = 0;
                    scan_pos  = 0;
                    clears_seen++;
                end
                mpfb_pkg::CMD_REFRESH: begin
                    if (scan_pos < mpfb_pkg::HEADER_LEN) begin
                        b.control_byte = mpfb_pkg::CTRL_COMMAND;
                        if (scan_pos == 0)
                            b.payload = mpfb_pkg::PAGE_BASE + 8'(scan_page);
                        else if (scan_pos == 1)
                            b.payload = mpfb_pkg::COL_LOW_CMD;
                        else
                            b.payload = mpfb_pkg::COL_HIGH_CMD;
                    end else begin
                        b.control_byte = mpfb_pkg::CTRL_DATA;
                        b.payload      = shadow_store[scan_page * mpfb_pkg::COLUMNS +
                                                      scan_pos - mpfb_pkg::HEADER_LEN];
                        b.frame_end    = (scan_page == mpfb_pkg::PAGES - 1) &&
                                         (scan_pos - mpfb_pkg::HEADER_LEN ==
                                          mpfb_pkg::COLUMNS - 1);
                    end
                    bytes_due.push_back(b);
                    scan_pos++;
                    if (scan_pos == mpfb_pkg::HEADER_LEN + mpfb_pkg::COLUMNS) begin
                        scan_pos  = 0;
                        scan_page = (scan_page + 1) % mpfb_pkg::PAGES;
                    end
                end
                mpfb_pkg::CMD_RAW: begin
                    b.control_byte = r.raw_is_data ? mpfb_pkg::CTRL_DATA
                                                   : mpfb_pkg::CTRL_COMMAND;
                    b.payload      = r.raw_value;
                    bytes_due.push_back(b);
                end
                default: ;
            endcase
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(logic [6:0] ctrl, logic [7:0] payload, logic frame_end);
            t_panel_byte want;
            if (bytes_due.size() == 0) begin
                $display("%0t: unrequested byte, expected none, actual ctrl %0h payload %0h end %0b",
                         $time, ctrl, payload, frame_end);
                mismatches++;
                return;
            end
            want = bytes_due.pop_front();
            bytes_checked++;
            if (frame_end === 1'b1) frames_seen++;
            field_check("control_byte", want.control_byte, ctrl);
            field_check("payload", want.payload, payload);
            field_check("frame_end", want.frame_end, frame_end);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_gap_pct;
    int   sink_stall_pct;
    int   requests_sent;
    int   stall_count;
    logic [6:0] recent_x;
    logic [5:0] recent_y;

    panel_scoreboard board = new();

    mpfb_req_if req_bus ();
    mpfb_rsp_if rsp_bus ();

    mono_page_framebuffer_scanout DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic t_panel_req make_req(logic [2:0] cmd, logic [6:0] x, logic [5:0] y,
                                            logic [7:0] raw, logic is_data);
        t_panel_req r;
        r.command     = cmd;
        r.pixel_x     = x;
        r.pixel_y     = y;
        r.raw_value   = raw;
        r.raw_is_data = is_data;
        return r;
    endfunction

    // Bias pixels toward the first two pages, which the scanner reaches soon
    // after a clear, and often hit the byte just touched to exercise forwarding.
    function automatic t_panel_req random_request();
        t_panel_req  r;
        int unsigned roll;
        roll          = $urandom_range(999);
        r.raw_value   = 8'($urandom_range(255));
        r.raw_is_data = 1'($urandom_range(1));
        if ($urandom_range(3) == 0) begin
            r.pixel_x = recent_x;
            r.pixel_y = {recent_y[5:3], 3'($urandom_range(7))};
        end else begin
            r.pixel_x = 7'($urandom_range(127));
            r.pixel_y = ($urandom_range(1) != 0) ? 6'($urandom_range(15))
                                                 : 6'($urandom_range(63));
        end
        recent_x = r.pixel_x;
        recent_y = r.pixel_y;
        if (roll < 350)
            r.command = mpfb_pkg::CMD_SET_PIXEL;
        else if (roll < 500)
            r.command = mpfb_pkg::CMD_CLR_PIXEL;
        else if (roll < 800)
            r.command = mpfb_pkg::CMD_REFRESH;
        else if (roll < 930)
            r.command = mpfb_pkg::CMD_RAW;
        else if (roll < 985)
            r.command = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        else
            r.command = mpfb_pkg::CMD_CLEAR_ALL;
        return r;
    endfunction

    // Present one request, idle at random first, and hold it until the block takes it.
    // Valid is left high after the handshake so back-to-back requests need no bubble.
    task automatic send_request(t_panel_req r);
        while ($urandom_range(99) < src_gap_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.command     <= r.command;
        req_bus.pixel_x     <= r.pixel_x;
        req_bus.pixel_y     <= r.pixel_y;
        req_bus.raw_value   <= r.raw_value;
        req_bus.raw_is_data <= r.raw_is_data;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        board.note_request(r);
        requests_sent++;
    endtask

    task automatic send_random(int count);
        repeat (count) send_request(random_request());
    endtask

    // Response side: check each byte taken, then stall at random for the next cycle.
    // Hold ready low through reset.
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
                board.check_response(rsp_bus.control_byte, rsp_bus.payload, rsp_bus.frame_end);
            rsp_bus.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: count cycles where neither channel moves anything. Reset and
    // clear-all sweeps stall the request side for a whole store pass, so the
    // limit is sized well above that.
    initial begin
        stall_count = 0;
        while (stall_count < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                stall_count = 0;
            else
                stall_count++;
        end
        $display("%0t: watchdog expired, no traffic for %0d cycles, %0d bytes still due",
                 $time, WATCHDOG_LIMIT, board.bytes_due.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        rst_n               <= 1'b0;
        req_bus.valid       <= 1'b0;
        req_bus.command     <= mpfb_pkg::CMD_SET_PIXEL;
        req_bus.pixel_x     <= '0;
        req_bus.pixel_y     <= '0;
        req_bus.raw_value   <= '0;
        req_bus.raw_is_data <= 1'b0;
        requests_sent       = 0;
        recent_x            = '0;
        recent_y            = '0;
        src_gap_pct         = 16;
        sink_stall_pct      = 52;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: panel corners, same-byte back-to-back updates, raw bytes of
        // both kinds, unused codes, a refresh page header, and clear-all rewind.
        send_request(make_req(mpfb_pkg::CMD_SET_PIXEL, 7'd0, 6'd0, 8'h00, 1'b0));
        send_request(make_req(mpfb_pkg::CMD_SET_PIXEL, 7'd0, 6'd1, 8'h00, 1'b0));
        send_request(make_req(mpfb_pkg::CMD_SET_PIXEL, 7'd127, 6'd63, 8'hFF, 1'b1));
        send_request(make_req(mpfb_pkg::CMD_SET_PIXEL, 7'd127, 6'd0, 8'h00, 1'b0));
        send_request(make_req(mpfb_pkg::CMD_CLR_PIXEL, 7'd127, 6'd63, 8'hFF, 1'b1));
        send_request(make_req(mpfb_pkg::CMD_SET_PIXEL, 7'd0, 6'd63, 8'h00, 1'b0));
        send_request(make_req(mpfb_pkg::CMD_CLR_PIXEL, 7'd0, 6'd1, 8'h00, 1'b0));
        send_request(make_req(mpfb_pkg::CMD_RAW, 7'd0, 6'd0, 8'h00, 1'b0));
        send_request(make_req(mpfb_pkg::CMD_RAW, 7'd127, 6'd63, 8'hFF, 1'b1));
        send_request(make_req(mpfb_pkg::CMD_RAW, 7'd0, 6'd0, 8'hA5, 1'b0));
        send_request(make_req(CMD_FIRST_UNUSED, 7'd127, 6'd63, 8'hFF, 1'b1));
        send_request(make_req(CMD_FIRST_UNUSED + 3'd1, 7'd0, 6'd0, 8'h00, 1'b0));
        send_request(make_req(CMD_LAST_UNUSED, 7'd127, 6'd63, 8'hFF, 1'b1));
        repeat (5) send_request(make_req(mpfb_pkg::CMD_REFRESH, 7'd0, 6'd0, 8'h00, 1'b0));
        send_request(make_req(mpfb_pkg::CMD_CLEAR_ALL, 7'd127, 6'd63, 8'hFF, 1'b1));
        repeat (4) send_request(make_req(mpfb_pkg::CMD_REFRESH, 7'd127, 6'd63, 8'hFF, 1'b1));

        send_random(RANDOM_PER_PHASE);

        // Swap the pressure: slow sender, eager receiver
        src_gap_pct    = 52;
        sink_stall_pct = 16;
        send_random(RANDOM_PER_PHASE);

        // Run flat out on both sides
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        send_random(RANDOM_PER_PHASE);

        // Drop valid, drain what is due, then watch a few cycles for strays
        req_bus.valid <= 1'b0;
        while (board.bytes_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests including %0d store clears; checked %0d panel bytes.",
                 requests_sent, board.clears_seen, board.bytes_checked);
        $display("Refresh stream crossed %0d frame ends; %0d field mismatches.",
                 board.frames_seen, board.mismatches);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/mpfb_pkg.sv
hw/rtl/mpfb_if.sv
hw/rtl/mpfb_scan.sv
hw/rtl/mono_page_framebuffer_scanout.sv
hw/rtl/mpfb_checker.sv
tb/tb_mono_page_framebuffer_scanout.sv
